// ===== src/ps2ct_pkg.sv =====
// Package for the PS/2 mouse packet cursor tracker.
// Holds coordinate widths, reset resolutions, register indexes, phase codes
// and the clamped axis-move function. No dependencies.
package ps2ct_pkg;

    localparam int COORD_BITS   = 12;
    localparam int CFG_IDX_BITS = 1;

    typedef logic [COORD_BITS-1:0]   coord_t;
    typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

    localparam coord_t DEF_WIDTH   = coord_t'(320);
    localparam coord_t DEF_HEIGHT  = coord_t'(200);
    localparam coord_t DEF_POS_X   = coord_t'(320 / 2);
    localparam coord_t DEF_POS_Y   = coord_t'(200 / 2);

    localparam cfg_idx_t REG_SCREEN_WIDTH  = cfg_idx_t'(0);
    localparam cfg_idx_t REG_SCREEN_HEIGHT = cfg_idx_t'(1);

    // Packet byte position, one-hot
    typedef enum logic [2:0] {
        PH_FLAGS = 3'b001,
        PH_DX    = 3'b010,
        PH_DY    = 3'b100
    } phase_t;

    // Add a 9-bit signed delta {sign, mag} to pos, clamp to 0..limit-1 (0 if limit is 0)
    function automatic coord_t move_axis(
        input coord_t     pos,
        input logic       sign,
        input logic [7:0] mag,
        input coord_t     limit
    );
        logic signed [COORD_BITS+1:0] sum;
        logic signed [COORD_BITS+1:0] lim;
        coord_t                       res;
        sum = $signed({2'b00, pos}) + $signed({{(COORD_BITS-7){sign}}, sign, mag});
        lim = $signed({2'b00, limit});
        if (sum >= lim)
        begin
            if (limit == '0)
                res = '0;
            else
                res = limit - coord_t'(1);
        end
        else if (sum[COORD_BITS+1])
        begin
            res = '0;
        end
        else
        begin
            res = sum[COORD_BITS-1:0];
        end
        return res;
    endfunction

endpackage

// ===== src/ps2ct_if.sv =====
// Channel interfaces for the PS/2 mouse packet cursor tracker.
// Depends on ps2ct_pkg for the coordinate type.
interface ps2ct_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ps2ct_snap_if;
    logic               valid;
    logic               ready;
    logic               btn_left;
    logic               btn_right;
    logic               btn_middle;
    ps2ct_pkg::coord_t  cursor_x;
    ps2ct_pkg::coord_t  cursor_y;
    logic               packet_done;

    modport source (output valid, output btn_left, output btn_right, output btn_middle,
                    output cursor_x, output cursor_y, output packet_done, input ready);
    modport sink   (input valid, input btn_left, input btn_right, input btn_middle,
                    input cursor_x, input cursor_y, input packet_done, output ready);
endinterface

// ===== src/ps2_mouse_packet_cursor_tracker_core.sv =====
// Top level of the PS/2 mouse packet cursor tracker.
// Depends on ps2ct_pkg and the channel interfaces in ps2ct_if.sv.
//
// Usage:
//   bytes     : raw mouse bytes in, valid/ready request per byte.
//   snapshots : one snapshot (buttons, cursor x/y, packet_done) per byte.
//   cfg_*     : plain write port; index 0 sets screen width, index 1 sets
//               screen height. A write recenters that axis. Write only while
//               idle.
// An accepted byte waits in the input register, then the decode/clamp logic
// loads the output register with its snapshot.
// Throughput is one byte per cycle while the receiver keeps snapshots.ready
// high. A byte is taken while the previous snapshot still waits.
// Reset: 320x200 screen, cursor at 160,100, buttons clear, and the first byte
// received afterwards is dropped (its snapshot still goes out, not done).
// When the receiver stalls, the output register holds its snapshot and the
// input register fills; bytes.ready then drops until snapshots.ready returns.
module ps2_mouse_packet_cursor_tracker_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  ps2ct_pkg::cfg_idx_t cfg_index,
    input  ps2ct_pkg::coord_t   cfg_data,
    ps2ct_byte_if.sink          bytes,
    ps2ct_snap_if.source        snapshots
);
    import ps2ct_pkg::*;

    // input register
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;

    // tracker state
    logic   skip_reg, skip_next;
    phase_t phase_reg, phase_next;
    logic   sign_x_reg, sign_x_next;
    logic   sign_y_reg, sign_y_next;
    logic [2:0] buttons_reg, buttons_next;
    coord_t width_reg, width_next;
    coord_t height_reg, height_next;
    coord_t pos_x_reg, pos_x_next;
    coord_t pos_y_reg, pos_y_next;
    logic   done_next;

    // output register
    logic       out_valid_reg, out_valid_next;
    logic [2:0] out_buttons_reg;
    coord_t     out_x_reg, out_y_reg;
    logic       out_done_reg;

    logic out_advance;
    logic step;
    logic in_take;

    assign out_advance  = !out_valid_reg || snapshots.ready;
    assign step         = in_valid_reg && out_advance;
    assign bytes.ready  = !in_valid_reg || out_advance;
    assign in_take      = bytes.valid && bytes.ready;

    always_comb
    begin
        if (in_take)
            in_valid_next = 1'b1;
        else if (step)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        if (step)
            out_valid_next = 1'b1;
        else if (snapshots.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_comb
    begin
        skip_next    = skip_reg;
        phase_next   = phase_reg;
        sign_x_next  = sign_x_reg;
        sign_y_next  = sign_y_reg;
        buttons_next = buttons_reg;
        width_next   = width_reg;
        height_next  = height_reg;
        pos_x_next   = pos_x_reg;
        pos_y_next   = pos_y_reg;
        done_next    = 1'b0;

        if (cfg_we)
        begin
            case (cfg_index)
                REG_SCREEN_WIDTH:
                begin
                    width_next = cfg_data;
                    pos_x_next = cfg_data >> 1;
                end
                REG_SCREEN_HEIGHT:
                begin
                    height_next = cfg_data;
                    pos_y_next  = cfg_data >> 1;
                end
                default:
                begin
                    width_next = width_reg;
                end
            endcase
        end
        else if (step)
        begin
            if (skip_reg)
            begin
                // drop the first byte after reset
                skip_next = 1'b0;
            end
            else
            begin
                case (phase_reg)
                    PH_FLAGS:
                    begin
                        buttons_next = in_byte_reg[2:0];
                        sign_x_next  = in_byte_reg[4];
                        sign_y_next  = in_byte_reg[5];
                        phase_next   = PH_DX;
                    end
                    PH_DX:
                    begin
                        pos_x_next = move_axis(pos_x_reg, sign_x_reg, in_byte_reg, width_reg);
                        phase_next = PH_DY;
                    end
                    PH_DY:
                    begin
                        pos_y_next = move_axis(pos_y_reg, sign_y_reg, in_byte_reg, height_reg);
                        phase_next = PH_FLAGS;
                        done_next  = 1'b1;
                    end
                    default:
                    begin
                        phase_next = PH_FLAGS;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            skip_reg      <= 1'b1;
            phase_reg     <= PH_FLAGS;
            sign_x_reg    <= 1'b0;
            sign_y_reg    <= 1'b0;
            buttons_reg   <= '0;
            width_reg     <= DEF_WIDTH;
            height_reg    <= DEF_HEIGHT;
            pos_x_reg     <= DEF_POS_X;
            pos_y_reg     <= DEF_POS_Y;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            skip_reg      <= skip_next;
            phase_reg     <= phase_next;
            sign_x_reg    <= sign_x_next;
            sign_y_reg    <= sign_y_next;
            buttons_reg   <= buttons_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            pos_x_reg     <= pos_x_next;
            pos_y_reg     <= pos_y_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
            in_byte_reg <= bytes.rx_byte;
        if (step)
        begin
            out_buttons_reg <= buttons_next;
            out_x_reg       <= pos_x_next;
            out_y_reg       <= pos_y_next;
            out_done_reg    <= done_next;
        end
    end

    assign snapshots.valid       = out_valid_reg;
    assign snapshots.btn_left    = out_buttons_reg[0];
    assign snapshots.btn_right   = out_buttons_reg[1];
    assign snapshots.btn_middle  = out_buttons_reg[2];
    assign snapshots.cursor_x    = out_x_reg;
    assign snapshots.cursor_y    = out_y_reg;
    assign snapshots.packet_done = out_done_reg;

`ifndef SYNTHESIS
    a_done_after_dy: assert property (@(posedge clk) disable iff (!rst_n)
        (step && !cfg_we && !skip_reg && phase_reg == PH_DY)
        |=> (out_valid_reg && out_done_reg))
        else $error("third packet byte did not report packet_done");

    a_skip_stays_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !skip_reg |=> !skip_reg)
        else $error("skip flag set again after reset");

    a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !snapshots.ready) |-> !bytes.ready)
        else $error("input taken while both stages are full");

    a_width_recenters: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_we && cfg_index == REG_SCREEN_WIDTH)
        |=> (pos_x_reg == ($past(cfg_data) >> 1)))
        else $error("width write did not recenter x");
`endif

endmodule
